FILE: rtl/framebuffer_pixel_writer_unit_assert.svh
// assertion macros for the framebuffer pixel writer
`ifndef FRAMEBUFFER_PIXEL_WRITER_UNIT_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_WRITER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// clocked property, switched off while reset is asserted
`define FPW_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpw assertion failed");
// clocked property, checked during reset too
`define FPW_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fpw assertion failed");
`else
`define FPW_ASSERT(label, clk, rst_n, prop)
`define FPW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/fpw_pkg.sv
// shared types, constants and helpers of the framebuffer pixel writer
`timescale 1ns / 1ps
`default_nettype none

package fpw_pkg;

    // largest clip extent
    localparam int MAX_DIM = 4096;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_BPP         = 3'd0;
    localparam logic [2:0] REG_ROW_PITCH   = 3'd1;
    localparam logic [2:0] REG_CLIP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_CLIP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FRAME_BASE  = 3'd4;
    localparam logic [2:0] REG_RED         = 3'd5;
    localparam logic [2:0] REG_GREEN       = 3'd6;
    localparam logic [2:0] REG_BLUE        = 3'd7;

    // supported pixel depths
    localparam logic [5:0] BPP_1  = 6'd1;
    localparam logic [5:0] BPP_2  = 6'd2;
    localparam logic [5:0] BPP_4  = 6'd4;
    localparam logic [5:0] BPP_8  = 6'd8;
    localparam logic [5:0] BPP_15 = 6'd15;
    localparam logic [5:0] BPP_16 = 6'd16;
    localparam logic [5:0] BPP_24 = 6'd24;
    localparam logic [5:0] BPP_32 = 6'd32;

    localparam logic [5:0] BPP_RESET = BPP_32;

    // byte enable codes
    localparam logic [3:0] BE_WORD  = 4'hF;
    localparam logic [3:0] BE_TRIPLE = 4'h7;
    localparam logic [3:0] BE_HALF  = 4'h3;
    localparam logic [3:0] BE_BYTE  = 4'h1;

    typedef struct packed {
        logic [5:0]  pixel_depth;
        logic [15:0] row_pitch;
        logic [12:0] clip_width;
        logic [12:0] clip_height;
        logic [31:0] frame_base;
        logic [10:0] red_layout;
        logic [10:0] green_layout;
        logic [10:0] blue_layout;
    } cfg_t;

    // register file contents after reset
    localparam cfg_t CFG_RESET = {BPP_RESET, 16'd0, 13'd0, 13'd0, 32'd0,
                                  11'd0, 11'd0, 11'd0};

    typedef struct packed {
        logic [5:0] len;
        logic [4:0] off;
    } chan_layout_t;

    typedef struct packed {
        logic signed [15:0] x_pos;
        logic signed [15:0] y_pos;
        logic [23:0]        pixel_color;
    } pixel_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [31:0] byte_address;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
        logic [7:0]  bit_mask;
    } pixel_out_t;

    // whole part of 2^len / 255: one 0x01 byte per full octet of len, shifted by len mod 8
    function automatic logic [22:0] chan_q_coef(input logic [4:0] len);
        logic [23:0] q;
        q = 24'd0;
        for (int j = 0; j < 3; j++)
        begin
            if (j < int'(len[4:3]))
            begin
                q[8*j] = 1'b1;
            end
        end
        q = q << len[2:0];
        return q[22:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/framebuffer_pixel_writer_unit.sv
// top level of the framebuffer pixel writer: config port, input register, formatter, result register
`timescale 1ns / 1ps
`default_nettype none
`include "framebuffer_pixel_writer_unit_assert.svh"

// framebuffer pixel writer: takes one pixel item (x, y, rgb888 color) per clock and returns
// exactly one result item for it, a memory write request (byte address, little-endian data,
// byte enables, bit mask) or, for a clipped point or an unsupported depth, an item with
// write_enable low and all other fields zero. throughput is one item per clock unless
// px_ready drops; an accepted item is held in the input register and its result in the
// result register, the two that bracket the formatter (row pitch multiply, three channel
// scalers with their reciprocal multiplies). the result register and input register form a
// two-deep pipeline, so a new item is taken while a finished result waits for wr_ready;
// px_ready drops only when both hold an item and wr_ready is low.
// registers are written through the apb-style port at byte address 4*index and must only
// change while no item is in flight.

module framebuffer_pixel_writer_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // pixel item channel
    input  wire logic                       px_valid,
    output logic                            px_ready,
    input  wire fpw_pkg::pixel_in_t         px_item,
    // write request channel
    output logic                            wr_valid,
    input  wire logic                       wr_ready,
    output fpw_pkg::pixel_out_t             wr_item,
    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fpw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fpw_pkg::DATA_W-1:0] pwdata,
    output logic      [fpw_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import fpw_pkg::*;

    cfg_t       cfg;

    // input register stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    pixel_in_t  s1_item_reg;
    pixel_in_t  s1_item_next;

    // result register stage
    logic       wr_valid_reg;
    logic       wr_valid_next;
    pixel_out_t wr_item_reg;
    pixel_out_t wr_item_next;

    pixel_out_t fmt_res;
    logic       px_accept;
    logic       s2_load;
    logic       s1_adv;

    fpw_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // result slot frees when empty or being drained this cycle
    assign s2_load   = !wr_valid_reg || wr_ready;
    assign s1_adv    = s1_valid_reg && s2_load;
    assign px_ready  = !s1_valid_reg || s2_load;
    assign px_accept = px_valid && px_ready;

    fpw_formatter u_fmt (
        .cfg  (cfg),
        .item (s1_item_reg),
        .res  (fmt_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_item_next  = s1_item_reg;
        wr_valid_next = wr_valid_reg;
        wr_item_next  = wr_item_reg;
        if (px_accept)
        begin
            s1_valid_next = 1'b1;
            s1_item_next  = px_item;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s2_load)
        begin
            wr_valid_next = s1_valid_reg;
        end
        if (s1_adv)
        begin
            wr_item_next = fmt_res;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        wr_item_reg <= wr_item_next;
    end

    assign wr_valid = wr_valid_reg;
    assign wr_item  = wr_item_reg;

    // a dropped point leaves every write field at zero
    `FPW_ASSERT(a_drop_zero, clk, rst_n, (wr_valid && !wr_item.write_enable) |-> (wr_item.byte_address == 32'd0 && wr_item.write_data == 32'd0 && wr_item.byte_enable == 4'd0 && wr_item.bit_mask == 8'd0))
    // a real write carries a legal enable code and a nonempty mask
    `FPW_ASSERT(a_write_shape, clk, rst_n, (wr_valid && wr_item.write_enable) |-> ((wr_item.byte_enable == BE_WORD || wr_item.byte_enable == BE_TRIPLE || wr_item.byte_enable == BE_HALF || wr_item.byte_enable == BE_BYTE) && wr_item.bit_mask != 8'd0))
    // multi-byte writes always replace the whole first byte
    `FPW_ASSERT(a_wide_mask, clk, rst_n, (wr_valid && wr_item.write_enable && wr_item.byte_enable != BE_BYTE) |-> (wr_item.bit_mask == 8'hFF))
    // an item held in the input register is not lost while the result stalls
    `FPW_ASSERT(a_hold_stage, clk, rst_n, (s1_valid_reg && wr_valid_reg && !wr_ready) |=> s1_valid_reg)

endmodule

`default_nettype wire

FILE: rtl/fpw_cfg_regs.sv
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
`default_nettype none

module fpw_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fpw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fpw_pkg::DATA_W-1:0] pwdata,
    output logic      [fpw_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output fpw_pkg::cfg_t                   cfg
);
    import fpw_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_BPP:         cfg_next.pixel_depth    = pwdata[5:0];
                REG_ROW_PITCH:   cfg_next.row_pitch      = pwdata[15:0];
                REG_CLIP_WIDTH:  cfg_next.clip_width     = pwdata[12:0];
                REG_CLIP_HEIGHT: cfg_next.clip_height    = pwdata[12:0];
                REG_FRAME_BASE:  cfg_next.frame_base     = pwdata[31:0];
                REG_RED:         cfg_next.red_layout     = pwdata[10:0];
                REG_GREEN:       cfg_next.green_layout   = pwdata[10:0];
                REG_BLUE:        cfg_next.blue_layout    = pwdata[10:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_BPP:         prdata = {26'd0, cfg_reg.pixel_depth};
            REG_ROW_PITCH:   prdata = {16'd0, cfg_reg.row_pitch};
            REG_CLIP_WIDTH:  prdata = {19'd0, cfg_reg.clip_width};
            REG_CLIP_HEIGHT: prdata = {19'd0, cfg_reg.clip_height};
            REG_FRAME_BASE:  prdata = cfg_reg.frame_base;
            REG_RED:         prdata = {21'd0, cfg_reg.red_layout};
            REG_GREEN:       prdata = {21'd0, cfg_reg.green_layout};
            REG_BLUE:        prdata = {21'd0, cfg_reg.blue_layout};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/fpw_chan_scale.sv
// one color channel: rounded scale of an 8-bit component to its length, then shift to offset
`timescale 1ns / 1ps
`default_nettype none

module fpw_chan_scale (
    input  wire logic [7:0]            chan,
    input  wire fpw_pkg::chan_layout_t layout,
    output logic      [31:0]           placed
);
    import fpw_pkg::*;

    // c*(2^L-1)+127 = 255*c*Q + (c*(2^(L mod 8)-1)+127), Q = whole part of 2^L/255
    logic [22:0] q_coef;
    logic [30:0] whole_part;
    logic [14:0] rem_sum;
    logic [30:0] rem_prod;
    logic [7:0]  rem_quot;
    logic [30:0] scaled;
    logic [31:0] chan_val;

    assign q_coef     = chan_q_coef(layout.len[4:0]);
    assign whole_part = 31'({23'd0, chan} * {8'd0, q_coef});
    assign rem_sum    = 15'({7'd0, chan} << layout.len[2:0]) - {7'd0, chan} + 15'd127;
    // divide by 255 via reciprocal, exact below 2^15
    assign rem_prod   = 31'({16'd0, rem_sum} * 31'd32897);
    assign rem_quot   = rem_prod[30:23];
    assign scaled     = whole_part + {23'd0, rem_quot};

    always_comb
    begin
        if (layout.len == 6'd0)
        begin
            chan_val = '0;
        end
        else if (layout.len >= 6'd31)
        begin
            chan_val = {24'd0, chan};
        end
        else
        begin
            chan_val = {1'b0, scaled};
        end
    end

    assign placed = chan_val << layout.off;

endmodule

`default_nettype wire

FILE: rtl/fpw_formatter.sv
// clip, pixel format conversion and address generation for one item
`timescale 1ns / 1ps
`default_nettype none

module fpw_formatter (
    input  wire fpw_pkg::cfg_t      cfg,
    input  wire fpw_pkg::pixel_in_t item,
    output fpw_pkg::pixel_out_t     res
);
    import fpw_pkg::*;

    function automatic logic [3:0] color_index(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
        logic [3:0] idx;
        idx    = 4'd0;
        idx[2] = (r > 8'd64);
        idx[1] = (g > 8'd64);
        idx[0] = (b > 8'd64);
        idx[3] = (r > 8'd128) || (g > 8'd128) || (b > 8'd128);
        return idx;
    endfunction

    logic [15:0]  xr;
    logic [15:0]  yr;
    logic [7:0]   r;
    logic [7:0]   g;
    logic [7:0]   b;
    logic [12:0]  cw_eff;
    logic [12:0]  ch_eff;
    logic         clipped;
    chan_layout_t lay_r;
    chan_layout_t lay_g;
    chan_layout_t lay_b;
    logic [31:0]  placed_r;
    logic [31:0]  placed_g;
    logic [31:0]  placed_b;
    logic [31:0]  packed_px;
    logic [15:0]  luma_sum;
    logic [7:0]   luma;
    logic [3:0]   cidx;
    logic [31:0]  row_off;
    logic [31:0]  xoff;
    logic [31:0]  data;
    logic [3:0]   be;
    logic [7:0]   mask;
    logic         ok;

    assign xr = item.x_pos;
    assign yr = item.y_pos;
    assign r  = item.pixel_color[23:16];
    assign g  = item.pixel_color[15:8];
    assign b  = item.pixel_color[7:0];

    assign cw_eff  = (cfg.clip_width > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.clip_width;
    assign ch_eff  = (cfg.clip_height > 13'(MAX_DIM)) ? 13'(MAX_DIM) : cfg.clip_height;
    // negative coordinates carry bit 15 and so always fail the bound
    assign clipped = xr[15] || yr[15] || (xr >= {3'd0, cw_eff}) || (yr >= {3'd0, ch_eff});

    // channel layouts, with the standard layout of the depth when all lengths are zero
    always_comb
    begin
        lay_r = chan_layout_t'(cfg.red_layout);
        lay_g = chan_layout_t'(cfg.green_layout);
        lay_b = chan_layout_t'(cfg.blue_layout);
        if (lay_r.len == 6'd0 && lay_g.len == 6'd0 && lay_b.len == 6'd0)
        begin
            case (cfg.pixel_depth)
                BPP_32, BPP_24:
                begin
                    lay_r = '{len: 6'd8, off: 5'd16};
                    lay_g = '{len: 6'd8, off: 5'd8};
                    lay_b = '{len: 6'd8, off: 5'd0};
                end
                BPP_16:
                begin
                    lay_r = '{len: 6'd5, off: 5'd11};
                    lay_g = '{len: 6'd6, off: 5'd5};
                    lay_b = '{len: 6'd5, off: 5'd0};
                end
                default:
                begin
                    lay_r = '{len: 6'd5, off: 5'd10};
                    lay_g = '{len: 6'd5, off: 5'd5};
                    lay_b = '{len: 6'd5, off: 5'd0};
                end
            endcase
        end
    end

    fpw_chan_scale u_scale_r (
        .chan   (r),
        .layout (lay_r),
        .placed (placed_r)
    );

    fpw_chan_scale u_scale_g (
        .chan   (g),
        .layout (lay_g),
        .placed (placed_g)
    );

    fpw_chan_scale u_scale_b (
        .chan   (b),
        .layout (lay_b),
        .placed (placed_b)
    );

    assign packed_px = placed_r | placed_g | placed_b;

    assign luma_sum = 16'({8'd0, r} * 16'd77) + 16'({8'd0, g} * 16'd150)
                    + 16'({8'd0, b} * 16'd29);
    assign luma     = luma_sum[15:8];
    assign cidx     = color_index(r, g, b);

    assign row_off = {16'd0, yr} * {16'd0, cfg.row_pitch};

    always_comb
    begin
        ok   = 1'b1;
        xoff = '0;
        data = '0;
        be   = BE_BYTE;
        mask = 8'hFF;
        case (cfg.pixel_depth)
            BPP_32:
            begin
                xoff = {14'd0, xr, 2'b00};
                data = packed_px;
                be   = BE_WORD;
            end
            BPP_24:
            begin
                xoff = {15'd0, xr, 1'b0} + {16'd0, xr};
                data = {8'd0, packed_px[23:0]};
                be   = BE_TRIPLE;
            end
            BPP_16, BPP_15:
            begin
                xoff = {15'd0, xr, 1'b0};
                data = {16'd0, packed_px[15:0]};
                be   = BE_HALF;
            end
            BPP_8:
            begin
                xoff = {16'd0, xr};
                data = {28'd0, cidx};
            end
            BPP_4:
            begin
                xoff = {17'd0, xr[15:1]};
                mask = xr[0] ? 8'h0F : 8'hF0;
                data = {24'd0, xr[0] ? {4'd0, cidx} : {cidx, 4'd0}};
            end
            BPP_2:
            begin
                xoff = {18'd0, xr[15:2]};
                mask = 8'h03 << {~xr[1:0], 1'b0};
                data = {24'd0, 8'({6'd0, luma[7:6]} << {~xr[1:0], 1'b0})};
            end
            BPP_1:
            begin
                xoff = {19'd0, xr[15:3]};
                mask = 8'h01 << ~xr[2:0];
                data = {24'd0, (luma > 8'd127) ? mask : 8'h00};
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        if (ok && !clipped)
        begin
            res.write_enable = 1'b1;
            res.byte_address = cfg.frame_base + row_off + xoff;
            res.write_data   = data;
            res.byte_enable  = be;
            res.bit_mask     = mask;
        end
    end

endmodule

`default_nettype wire
